// ===== rtl/rgb2hsv_pkg.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV package
// Shared types and constants for the pipelined RGB to HSV converter.
// ----------------------------------------------------------------------------
package rgb2hsv_pkg;

  localparam int unsigned CodeW         = 8;
  localparam int unsigned HueW          = 15;
  localparam int unsigned QuoW          = 12;
  localparam int unsigned HueRemW       = CodeW + QuoW;
  localparam int unsigned SatRemW       = 2 * CodeW;
  localparam int unsigned StepsPerStage = 2;
  localparam int unsigned NumDivStages  = QuoW / StepsPerStage;

  localparam logic [HueW-1:0] HueSixth = HueW'(3840);
  localparam logic [HueW-1:0] HueTurn  = HueW'(23040);

  typedef enum logic [1:0] {
    SecRed   = 2'd0,
    SecGreen = 2'd1,
    SecBlue  = 2'd2
  } sector_e;

  typedef struct packed {
    logic [CodeW-1:0] red_in;
    logic [CodeW-1:0] green_in;
    logic [CodeW-1:0] blue_in;
    logic [CodeW-1:0] alpha_in;
  } req_t;

  typedef struct packed {
    logic [HueW-1:0]  hue_out;
    logic [CodeW-1:0] saturation_out;
    logic [CodeW-1:0] value_out;
    logic [CodeW-1:0] alpha_out;
  } rsp_t;

  typedef struct packed {
    logic                valid;
    sector_e             sector;
    logic                neg;
    logic                grey;
    logic                black;
    logic [HueRemW-1:0]  hue_rem;
    logic [QuoW-1:0]     hue_quo;
    logic [SatRemW-1:0]  sat_rem;
    logic [QuoW-1:0]     sat_quo;
    logic [CodeW-1:0]    delta;
    logic [CodeW-1:0]    vmax;
    logic [CodeW-1:0]    alpha;
  } pipe_t;

endpackage

// ===== rtl/rgb2hsv_front.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV front stage
// Finds the largest channel, the spread and the hue sector, and forms the
// numerators of the hue and saturation divisions.
// ----------------------------------------------------------------------------
module rgb2hsv_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               take_i,
  input  rgb2hsv_pkg::req_t  req_i,
  output rgb2hsv_pkg::pipe_t pipe_o
);
  import rgb2hsv_pkg::*;

  logic [CodeW-1:0] vmax, vmin, delta, diff_a, diff_b, mag;
  sector_e          sector;
  pipe_t            pipe_d, pipe_q;
  logic             valid_q;

  always_comb begin
    vmax = req_i.red_in;
    vmin = req_i.red_in;
    if (req_i.green_in > vmax) vmax = req_i.green_in;
    if (req_i.blue_in > vmax) vmax = req_i.blue_in;
    if (req_i.green_in < vmin) vmin = req_i.green_in;
    if (req_i.blue_in < vmin) vmin = req_i.blue_in;
    delta = vmax - vmin;

    if (req_i.red_in >= vmax) begin
      sector = SecRed;
      diff_a = req_i.green_in;
      diff_b = req_i.blue_in;
    end else if (req_i.green_in >= vmax) begin
      sector = SecGreen;
      diff_a = req_i.blue_in;
      diff_b = req_i.red_in;
    end else begin
      sector = SecBlue;
      diff_a = req_i.red_in;
      diff_b = req_i.green_in;
    end
    mag = (diff_a >= diff_b) ? (diff_a - diff_b) : (diff_b - diff_a);

    pipe_d         = '0;
    pipe_d.valid   = take_i;
    pipe_d.sector  = sector;
    pipe_d.neg     = diff_a < diff_b;
    pipe_d.grey    = delta == '0;
    pipe_d.black   = vmax == '0;
    pipe_d.hue_rem = ({mag, QuoW'(0)}) - ({4'b0, mag, CodeW'(0)});
    pipe_d.sat_rem = ({delta, CodeW'(0)}) - SatRemW'(delta);
    pipe_d.delta   = delta;
    pipe_d.vmax    = vmax;
    pipe_d.alpha   = req_i.alpha_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= pipe_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    pipe_q <= pipe_d;
  end

  always_comb begin
    pipe_o       = pipe_q;
    pipe_o.valid = valid_q;
  end

endmodule

// ===== rtl/rgb2hsv_div_step.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV division stage
// Produces two quotient bits of both the hue and the saturation division by
// shift and subtract, then registers the item.
// ----------------------------------------------------------------------------
module rgb2hsv_div_step (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rgb2hsv_pkg::pipe_t pipe_i,
  output rgb2hsv_pkg::pipe_t pipe_o
);
  import rgb2hsv_pkg::*;

  pipe_t pipe_d, pipe_q;
  logic  valid_q;
  logic  hue_bit, sat_bit;

  always_comb begin
    pipe_d  = pipe_i;
    hue_bit = 1'b0;
    sat_bit = 1'b0;
    for (int i = 0; i < StepsPerStage; i++) begin
      hue_bit = pipe_d.hue_rem >= {1'b0, pipe_d.delta, (QuoW-1)'(0)};
      if (hue_bit) begin
        pipe_d.hue_rem = pipe_d.hue_rem - {1'b0, pipe_d.delta, (QuoW-1)'(0)};
      end
      pipe_d.hue_quo = {pipe_d.hue_quo[QuoW-2:0], hue_bit};
      pipe_d.hue_rem = {pipe_d.hue_rem[HueRemW-2:0], 1'b0};

      sat_bit = pipe_d.sat_rem >= {1'b0, pipe_d.vmax, (CodeW-1)'(0)};
      if (sat_bit) begin
        pipe_d.sat_rem = pipe_d.sat_rem - {1'b0, pipe_d.vmax, (CodeW-1)'(0)};
      end
      pipe_d.sat_quo = {pipe_d.sat_quo[QuoW-2:0], sat_bit};
      pipe_d.sat_rem = {pipe_d.sat_rem[SatRemW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= pipe_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    pipe_q <= pipe_d;
  end

  always_comb begin
    pipe_o       = pipe_q;
    pipe_o.valid = valid_q;
  end

endmodule

// ===== rtl/rgb2hsv_back.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV back stage
// Places the hue quotient in its sector with floor rounding and wrap, applies
// the black and grey cases, and registers the result.
// ----------------------------------------------------------------------------
module rgb2hsv_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rgb2hsv_pkg::pipe_t pipe_i,
  output logic               valid_o,
  output rgb2hsv_pkg::rsp_t  rsp_o
);
  import rgb2hsv_pkg::*;

  logic [HueW-1:0] base, mag, hue_sum;
  logic [HueW:0]   hue_neg;
  rsp_t            rsp_d, rsp_q;
  logic            valid_q;

  always_comb begin
    case (pipe_i.sector)
      SecRed:   base = '0;
      SecGreen: base = HueW'(2 * HueSixth);
      SecBlue:  base = HueW'(4 * HueSixth);
      default:  base = '0;
    endcase

    mag     = HueW'(pipe_i.hue_quo) + HueW'(pipe_i.hue_rem != '0);
    hue_neg = {1'b0, base} - {1'b0, mag};
    if (!pipe_i.neg) begin
      hue_sum = base + HueW'(pipe_i.hue_quo);
    end else if (hue_neg[HueW]) begin
      hue_sum = hue_neg[HueW-1:0] + HueTurn;
    end else begin
      hue_sum = hue_neg[HueW-1:0];
    end

    rsp_d.hue_out        = (pipe_i.grey || pipe_i.black) ? '0 : hue_sum;
    rsp_d.saturation_out = pipe_i.black ? '0 : pipe_i.sat_quo[QuoW-1 -: CodeW];
    rsp_d.value_out      = pipe_i.vmax;
    rsp_d.alpha_out      = pipe_i.alpha;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= pipe_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

endmodule

// ===== rtl/rgb_to_hsv_converter_unit.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV converter unit
// Converts one 8-bit ARGB pixel per clock to fixed-point hue, saturation and
// value, with alpha passed through.
//
//   Channel   Handshake        Payload
//   request   start / busy     req_i   (red, green, blue, alpha codes)
//   result    valid_o strobe   rsp_o   (hue, saturation, value, alpha)
//
// A request is taken in every cycle in which start is high; busy is always
// low. Each result appears for one cycle, after passing through one front
// stage, six division stages of two quotient bits each and one output
// stage. The twelve-bit hue division sets the pipeline depth.
// Reset clears the valid bits of all stages. The receiver cannot stall.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  rgb2hsv_pkg::req_t req_i,
  output logic              valid_o,
  output rgb2hsv_pkg::rsp_t rsp_o
);
  import rgb2hsv_pkg::*;

  pipe_t pipe [NumDivStages+1];

  assign busy = 1'b0;

  rgb2hsv_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (start && !busy),
    .req_i  (req_i),
    .pipe_o (pipe[0])
  );

  for (genvar s = 0; s < NumDivStages; s++) begin : g_div
    rgb2hsv_div_step u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .pipe_i (pipe[s]),
      .pipe_o (pipe[s+1])
    );
  end

  rgb2hsv_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pipe_i  (pipe[NumDivStages]),
    .valid_o (valid_o),
    .rsp_o   (rsp_o)
  );

endmodule
